// ===== sv/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
package spq_pkg;

  localparam int unsigned SPQ_CAPACITY = 16;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned OCC_W        = 5;

  typedef enum logic [0:0] {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } spq_cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } spq_status_e;

  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;
  } spq_entry_t;

  typedef struct packed {
    logic                     enq;
    logic                     deq;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;
  } spq_op_t;

endpackage

// ===== sv/spq_cell.sv =====
// One slot of the sorted chain: holds an entry, shifts toward either neighbor.
module spq_cell
  import spq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  spq_op_t    op_i,
  input  spq_entry_t prev_i,
  input  logic       prev_gt_i,
  input  spq_entry_t next_i,
  output spq_entry_t entry_o,
  output logic       gt_o
);

  logic                     valid_q, valid_d;
  logic signed [DATA_W-1:0] key_q, key_d;
  logic signed [DATA_W-1:0] value_q, value_d;
  logic                     load;

  // Slot is free or holds a strictly smaller key than the incoming one.
  assign gt_o = !valid_q || (key_q < op_i.key);

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    value_d = value_q;
    load    = 1'b0;
    priority if (op_i.enq && gt_o && !prev_gt_i) begin
      valid_d = 1'b1;
      key_d   = op_i.key;
      value_d = op_i.value;
      load    = 1'b1;
    end else if (op_i.enq && gt_o && prev_gt_i) begin
      valid_d = prev_i.valid;
      key_d   = prev_i.key;
      value_d = prev_i.value;
      load    = 1'b1;
    end else if (op_i.deq) begin
      valid_d = next_i.valid;
      key_d   = next_i.key;
      value_d = next_i.value;
      load    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      key_q   <= key_d;
      value_q <= value_d;
    end
  end

  assign entry_o = '{valid: valid_q, key: key_q, value: value_q};

endmodule

// ===== sv/sorted_priority_queue_top.sv =====
// Top level of the sorted priority queue: cell chain, count and result register.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid_i/in_stall_o | command_i, value_i, priority_key_i
//   out     | output    | out_valid_o/out_stall_i | removed_value_o, status_o,
//           |           |                       | occupancy_o, front_value_o
//
// One item per cycle while no result is stalled; its result is registered on acceptance. All cells
// compare against the new key in parallel and shift in the same edge.
// Reset empties the queue by clearing every cell's valid bit.
// A stalled result holds the input side off until it is taken.
module sorted_priority_queue_top
  import spq_pkg::*;
#(
  parameter int unsigned CAPACITY = SPQ_CAPACITY
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     command_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic signed [DATA_W-1:0] priority_key_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] removed_value_o,
  output logic [1:0]               status_o,
  output logic [OCC_W-1:0]         occupancy_o,
  output logic signed [DATA_W-1:0] front_value_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  spq_entry_t               ent [CAPACITY];
  logic [CAPACITY-1:0]      gt;
  spq_op_t                  op;
  logic                     accept, is_deq, full, empty;
  logic [CNT_W-1:0]         count_q, count_d;
  logic                     out_valid_q;
  logic signed [DATA_W-1:0] removed_q, removed_d;
  logic signed [DATA_W-1:0] front_q, front_d, head_d;
  spq_status_e              status_q, status_d;
  logic [OCC_W-1:0]         occ_q, occ_d;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_deq     = (command_i == CMD_DEQ);
  assign full       = (count_q == CNT_W'(CAPACITY));
  assign empty      = (count_q == '0);

  assign op.enq   = accept && !is_deq && !full;
  assign op.deq   = accept && is_deq && !empty;
  assign op.key   = priority_key_i;
  assign op.value = value_i;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_entry_t prev_ent, next_ent;
    logic       prev_gt;
    if (i == 0) begin : g_first
      assign prev_ent = '0;
      assign prev_gt  = 1'b0;
    end else begin : g_mid
      assign prev_ent = ent[i-1];
      assign prev_gt  = gt[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_ent = '0;
    end else begin : g_inner
      assign next_ent = ent[i+1];
    end
    spq_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .op_i     (op),
      .prev_i   (prev_ent),
      .prev_gt_i(prev_gt),
      .next_i   (next_ent),
      .entry_o  (ent[i]),
      .gt_o     (gt[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (op.enq) begin
      count_d = count_q + CNT_W'(1);
    end else if (op.deq) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_comb begin
    head_d = ent[0].value;
    if (op.enq && gt[0]) begin
      head_d = value_i;
    end else if (op.deq) begin
      head_d = ent[1].value;
    end
    front_d   = (count_d == '0) ? '0 : head_d;
    removed_d = op.deq ? ent[0].value : '0;
    if (is_deq) begin
      status_d = empty ? STATUS_EMPTY : STATUS_OK;
    end else begin
      status_d = full ? STATUS_FULL : STATUS_OK;
    end
  end

  if (CNT_W >= OCC_W) begin : g_occ_trunc
    assign occ_d = count_d[OCC_W-1:0];
  end else begin : g_occ_ext
    assign occ_d = {{(OCC_W - CNT_W){1'b0}}, count_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      removed_q <= removed_d;
      status_q  <= status_d;
      occ_q     <= occ_d;
      front_q   <= front_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign removed_value_o = removed_q;
  assign status_o        = status_q;
  assign occupancy_o     = occ_q;
  assign front_value_o   = front_q;

endmodule

// ===== sv/spq_checker.sv =====
// Port-level checks for the sorted priority queue, bound to the top level.
module spq_checker
  import spq_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_stall_o,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic signed [DATA_W-1:0] removed_value_o,
  input logic [1:0]               status_o,
  input logic [OCC_W-1:0]         occupancy_o,
  input logic signed [DATA_W-1:0] front_value_o
);

  a_empty_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (occupancy_o == '0) |-> (front_value_o == '0))
    else $error("front value not zero on empty queue");

  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_EMPTY) |->
      (occupancy_o == '0) && (removed_value_o == '0))
    else $error("empty status with entries or removed value");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_FULL) |-> (removed_value_o == '0))
    else $error("full status with removed value");

  a_stall_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input accepted while result is stalled");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(removed_value_o)
      && $stable(status_o) && $stable(occupancy_o) && $stable(front_value_o))
    else $error("stalled result changed");

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .removed_value_o(removed_value_o),
  .status_o       (status_o),
  .occupancy_o    (occupancy_o),
  .front_value_o  (front_value_o)
);
